### hdl/mlru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlru_pkg: shared codes and types for the midpoint LRU order list
//
// Operation and status codes, and the control bundle that the list
// controller sends to every cell of the chain.
// ----------------------------------------------------------------------------
package mlru_pkg;

  localparam int OP_BITS   = 3;
  localparam int ST_BITS   = 2;
  localparam int PORT_ID_BITS   = 8;
  localparam int PORT_SIZE_BITS = 5;

  typedef logic [OP_BITS-1:0] op_t;
  typedef logic [ST_BITS-1:0] status_t;

  localparam op_t OP_PUT_MID     = 3'd0;
  localparam op_t OP_FORWARD     = 3'd1;
  localparam op_t OP_REMOVE_LAST = 3'd2;
  localparam op_t OP_REMOVE      = 3'd3;
  localparam op_t OP_CLEAR       = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic search;  // compare stored ids against the key
    logic commit;  // apply the operation to the stored ids
    op_t  op;
  } mlru_ctl_t;

endpackage

### hdl/mlru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlru_cell: one position of the ordered id list
//
// Holds the id at list position IDX. On a search it records whether it
// matches the key; the first-match, position and tail-id chains pass
// through it to the next cell. On a commit it loads the key or a
// neighbor's id as the operation requires.
// ----------------------------------------------------------------------------
module mlru_cell #(
  parameter int ID_BITS = 8,
  parameter int CW      = 5,
  parameter int PW      = 4,
  parameter int IDX     = 0
) (
  input  logic                clk,
  input  mlru_pkg::mlru_ctl_t ctl,
  input  logic [ID_BITS-1:0]  key_id,
  input  logic [CW-1:0]       count,
  input  logic [CW-1:0]       at_pos,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic [ID_BITS-1:0]  right_id,
  input  logic                right_first,
  input  logic                seen_in,
  input  logic [PW-1:0]       pos_in,
  input  logic [ID_BITS-1:0]  tail_in,
  output logic [ID_BITS-1:0]  data_out,
  output logic                first_out,
  output logic                seen_out,
  output logic [PW-1:0]       pos_out,
  output logic [ID_BITS-1:0]  tail_out
);
  import mlru_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [PW-1:0] IDX_P = PW'(IDX);

  logic [ID_BITS-1:0] data_r, data_nxt;
  logic               hit_r, hit_nxt;
  logic               is_last;

  assign is_last   = (count != '0) && (IDX_C == count - CW'(1));
  assign first_out = hit_r & ~seen_in;
  assign seen_out  = seen_in | hit_r;
  assign pos_out   = pos_in | (first_out ? IDX_P : '0);
  assign tail_out  = tail_in | (is_last ? data_r : '0);
  assign data_out  = data_r;

  always_comb begin
    hit_nxt = hit_r;
    if (ctl.search) begin
      hit_nxt = (data_r == key_id) && (IDX_C < count);
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (ctl.commit) begin
      unique case (ctl.op)
        OP_PUT_MID: begin
          if (IDX_C == at_pos) begin
            data_nxt = key_id;
          end else if (IDX_C > at_pos) begin
            data_nxt = left_id;
          end
        end
        OP_FORWARD: begin
          if (first_out) begin
            data_nxt = left_id;
          end else if (right_first) begin
            data_nxt = right_id;
          end
        end
        OP_REMOVE: begin
          // every position from the removed one backward closes the gap
          if (seen_out) begin
            data_nxt = right_id;
          end
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

endmodule

### hdl/midpoint_lru_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_lru_order: ordered id list with a balanced mid marker
//
// Keeps up to ENTRIES ids front to back in a chain of cells and answers
// put_mid, forward, remove_last, remove and clear with status, id and size.
// ----------------------------------------------------------------------------
// In the accept cycle all cells compare their id with the key in parallel and
// the back id is captured; in the update cycle the first match ripples down
// the cell chain, the mid and count are updated and the cells shift or swap
// in one step, writing the result into the output register. A new transaction
// is taken after the previous one's update cycle, also while its result waits
// on out_stall; the update cycle holds only when the output register is still
// full. The matching ripple through the cell chain sets the clock period for
// large ENTRIES. Stored ids are undefined until written; only positions below
// the list size are used.
module midpoint_lru_order #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mlru_pkg::OP_BITS-1:0]           in_operation,
  input  logic [mlru_pkg::PORT_ID_BITS-1:0]      in_entry_id,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mlru_pkg::ST_BITS-1:0]           out_status,
  output logic [mlru_pkg::PORT_ID_BITS-1:0]      out_removed_id,
  output logic [mlru_pkg::PORT_SIZE_BITS-1:0]    out_list_size
);
  import mlru_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = $clog2(ENTRIES);
  localparam int XW = CW + 1;
  localparam logic [CW-1:0] FULL_C = CW'(ENTRIES);

  // control state
  logic            busy_r, busy_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   mid_r, mid_nxt;
  // transaction payload
  op_t                op_r;
  logic [ID_BITS-1:0] id_r;
  logic [ID_BITS-1:0] tail_r;
  status_t            out_status_r, out_status_nxt;
  logic [ID_BITS-1:0] out_id_r, out_id_nxt;

  logic               accept, exec_go;
  logic [ID_BITS-1:0] in_id;
  logic [ID_BITS+PORT_ID_BITS-1:0] in_id_wide, out_id_wide;
  logic [CW+PORT_SIZE_BITS-1:0]    size_wide;
  logic [ID_BITS-1:0] key_id;
  mlru_ctl_t          ctl;
  logic [CW-1:0]      at_pos;
  logic               found;
  logic [PW-1:0]      found_pos;
  logic [ID_BITS-1:0] tail_id;
  logic               ok;

  logic [ID_BITS-1:0] data_w  [ENTRIES];
  logic               first_w [ENTRIES];
  logic               seen_w  [ENTRIES+1];
  logic [PW-1:0]      pos_w   [ENTRIES+1];
  logic [ID_BITS-1:0] tail_w  [ENTRIES+1];

  // mid arithmetic in a width that holds twice the mid plus two
  logic [XW-1:0] c_x, m_x, p_x, n_x, mm_x, mr_x;
  logic          put_lt;

  assign in_id_wide = {{ID_BITS{1'b0}}, in_entry_id};
  assign in_id      = in_id_wide[ID_BITS-1:0];

  assign accept  = in_valid & ~busy_r;
  assign exec_go = busy_r & (~out_valid_r | ~out_stall);
  assign in_stall = busy_r;
  assign key_id  = busy_r ? id_r : in_id;

  assign seen_w[0] = 1'b0;
  assign pos_w[0]  = '0;
  assign tail_w[0] = '0;
  assign found     = seen_w[ENTRIES];
  assign found_pos = pos_w[ENTRIES];
  assign tail_id   = tail_w[ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic [ID_BITS-1:0] left_id, right_id;
      logic               right_first;
      if (gi == 0) begin : g_front
        assign left_id = data_w[gi];
      end else begin : g_inner_l
        assign left_id = data_w[gi-1];
      end
      if (gi == ENTRIES - 1) begin : g_back
        assign right_id    = data_w[gi];
        assign right_first = 1'b0;
      end else begin : g_inner_r
        assign right_id    = data_w[gi+1];
        assign right_first = first_w[gi+1];
      end
      mlru_cell #(
        .ID_BITS(ID_BITS),
        .CW     (CW),
        .PW     (PW),
        .IDX    (gi)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .key_id     (key_id),
        .count      (count_r),
        .at_pos     (at_pos),
        .left_id    (left_id),
        .right_id   (right_id),
        .right_first(right_first),
        .seen_in    (seen_w[gi]),
        .pos_in     (pos_w[gi]),
        .tail_in    (tail_w[gi]),
        .data_out   (data_w[gi]),
        .first_out  (first_w[gi]),
        .seen_out   (seen_w[gi+1]),
        .pos_out    (pos_w[gi+1]),
        .tail_out   (tail_w[gi+1])
      );
    end
  endgenerate

  assign c_x    = XW'(count_r);
  assign m_x    = XW'(mid_r);
  assign p_x    = XW'(found_pos);
  assign put_lt = ((m_x << 1) + XW'(1)) < c_x;

  always_comb begin
    if (count_r == '0) begin
      at_pos = '0;
    end else if (put_lt) begin
      at_pos = CW'(mid_r);
    end else begin
      at_pos = CW'(m_x + XW'(1));
    end
  end

  always_comb begin
    ok             = 1'b0;
    count_nxt      = count_r;
    mid_nxt        = mid_r;
    out_status_nxt = ST_OK;
    out_id_nxt     = id_r;
    n_x            = c_x - XW'(1);
    mm_x           = m_x;
    mr_x           = m_x;
    unique case (op_r)
      OP_PUT_MID: begin
        if (count_r == '0) begin
          ok        = 1'b1;
          count_nxt = CW'(1);
          mid_nxt   = '0;
        end else if (count_r == FULL_C) begin
          out_status_nxt = ST_FULL;
        end else begin
          ok        = 1'b1;
          count_nxt = count_r + CW'(1);
          if (put_lt) begin
            mid_nxt = mid_r + PW'(1);
          end
        end
      end
      OP_FORWARD: begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else if (!found) begin
          out_status_nxt = ST_NOT_FOUND;
        end else begin
          ok = 1'b1;
        end
      end
      OP_REMOVE_LAST: begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
          out_id_nxt     = '0;
        end else begin
          out_id_nxt = tail_r;
          count_nxt  = count_r - CW'(1);
          if (n_x == '0) begin
            mid_nxt = '0;
          end else begin
            // mid at the back first passes to the new back entry
            mm_x = (m_x >= n_x) ? n_x - XW'(1) : m_x;
            mr_x = ((n_x - XW'(1)) < (mm_x << 1)) ? mm_x - XW'(1) : mm_x;
            mid_nxt = PW'(mr_x);
          end
        end
      end
      OP_REMOVE: begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else if (!found) begin
          out_status_nxt = ST_NOT_FOUND;
        end else begin
          ok        = 1'b1;
          count_nxt = count_r - CW'(1);
          if ((p_x < m_x) || ((p_x == m_x) && (m_x != '0))) begin
            mm_x = m_x - XW'(1);
          end
          // rebalance by at most one place
          if (n_x == '0) begin
            mr_x = '0;
          end else if (((mm_x << 1) + XW'(2)) < n_x) begin
            mr_x = mm_x + XW'(1);
          end else if ((((mm_x << 1) + XW'(1)) > n_x) && (mm_x != '0)) begin
            mr_x = mm_x - XW'(1);
          end else begin
            mr_x = mm_x;
          end
          mid_nxt = PW'(mr_x);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
        mid_nxt   = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_comb begin
    ctl.search = accept;
    ctl.commit = exec_go & ok;
    ctl.op     = op_r;
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_go) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      mid_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        count_r <= count_nxt;
        mid_r   <= mid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      id_r   <= in_id;
      tail_r <= tail_id;
    end
    if (exec_go) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
    end
  end

  assign out_id_wide = {{PORT_ID_BITS{1'b0}}, out_id_r};
  assign size_wide   = {{PORT_SIZE_BITS{1'b0}}, count_r};

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_removed_id = out_id_wide[PORT_ID_BITS-1:0];
  assign out_list_size  = size_wide[PORT_SIZE_BITS-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_C)
    else $error("list size above capacity");

  a_mid_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) ? (mid_r == '0) : (CW'(mid_r) < count_r))
    else $error("mid marker outside the list");

  a_mid_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> ((c_x == (m_x << 1) + XW'(1)) || (c_x == (m_x << 1) + XW'(2))))
    else $error("mid marker out of balance");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (!busy_r && out_valid_r))
    else $error("update cycle did not complete the transaction");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a transaction in flight");

endmodule
